/* hdl/max_priority_queue_macros.svh */
// Assertion macros used by the checker file.
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hdl/mpq_pkg.sv */
`default_nettype none
package mpq_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int INDEX_WIDTH = $clog2(CAPACITY);

   localparam int RESULT_WIDTH    = 32;
   localparam int OCCUPANCY_WIDTH = 7;

   // Request codes.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                     req_type;
      logic signed [31:0]       value;
   } request_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0]  result_value;
      logic [1:0]                      status;
      logic [OCCUPANCY_WIDTH-1:0]      occupancy;
   } response_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type                  op;
      logic signed [DATA_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0]       count;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

/* hdl/mpq_cell.sv */
`default_nettype none
module mpq_cell (
   input  wire logic                                   clock,
   input  wire mpq_pkg::cell_ctrl_type                 ctrl,
   input  wire logic [mpq_pkg::INDEX_WIDTH-1:0]        cell_index,
   input  wire logic signed [mpq_pkg::DATA_WIDTH-1:0]  left_data,
   input  wire logic                                   left_keep,
   input  wire logic signed [mpq_pkg::DATA_WIDTH-1:0]  right_data,
   output logic signed [mpq_pkg::DATA_WIDTH-1:0]       data_out,
   output logic                                        keep_out
);
   import mpq_pkg::*;

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         occupied;

   // Entries are sorted greatest first; a cell keeps its entry on insert
   // when it is occupied and not smaller than the new value.
   assign occupied = COUNT_WIDTH'(cell_index) < ctrl.count;
   assign keep_out = occupied && (data_ff >= ctrl.value);
   assign data_out = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (keep_out) begin
               data_in = data_ff;
            end else if (left_keep) begin
               data_in = ctrl.value;
            end else begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

/* hdl/max_priority_queue.sv */
// Max-priority queue built as a sorted chain of cells, greatest entry in cell 0.
// A request latches into req_ff; from execute, rsp_valid_ff registers the result.
// A new request waits while busy, which is high in the execute state.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// Reset (synchronous, active high) empties the queue; cell contents are not cleared.
`default_nettype none
module max_priority_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire mpq_pkg::request_type   req_data,
   output logic                        rsp_valid,
   output mpq_pkg::response_type       rsp_data
);
   import mpq_pkg::*;

   // Control and request registers.
   state_type              state_ff, state_in;
   request_type            req_ff, req_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   response_type           rsp_data_ff, rsp_data_in;

   // Cell chain wiring.
   cell_ctrl_type                ctrl;
   logic signed [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic                         cell_keep [CAPACITY];

   logic is_full;
   logic is_empty;

   assign is_full  = count_ff == COUNT_WIDTH'(CAPACITY);
   assign is_empty = count_ff == '0;

   // Next state, count update, cell command and response.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.value   = DATA_WIDTH'(req_ff.value);
      ctrl.count   = count_ff;

      case (state_ff)
         ST_IDLE: begin
            // Latch the request on the transfer and go execute it.
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.result_value = '0;
            rsp_data_in.status       = STATUS_OK;
            if (req_ff.req_type == REQ_INSERT) begin
               if (is_full) begin
                  // Drop the value and flag it.
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               if (is_empty) begin
                  rsp_data_in.result_value = -32'sd1;
                  rsp_data_in.status       = STATUS_EMPTY;
               end else begin
                  // Head of the chain is the maximum; shift everything left.
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - 1'b1;
                  rsp_data_in.result_value = RESULT_WIDTH'(cell_data[0]);
               end
            end
            rsp_data_in.occupancy = OCCUPANCY_WIDTH'(count_in);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Chain of cells: each sees its left and right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic                         left_keep;
      logic signed [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_head
         // Cell 0 takes the new value whenever it does not keep its own.
         assign left_data = ctrl.value;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      mpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (INDEX_WIDTH'(i)),
         .left_data  (left_data),
         .left_keep  (left_keep),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .keep_out   (cell_keep[i])
      );
   end

   assign busy      = state_ff == ST_EXEC;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* hdl/mpq_checker.sv */
`default_nettype none
`include "max_priority_queue_macros.svh"
module mpq_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   busy,
   input  wire mpq_pkg::request_type   req_data,
   input  wire logic                   rsp_valid,
   input  wire mpq_pkg::response_type  rsp_data
);
   import mpq_pkg::*;

   logic accepted;
   assign accepted = start && !busy && (req_data.req_type == REQ_INSERT || 1'b1);

   // An accepted transfer raises busy, and busy is followed by the response strobe.
   `MPQ_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy && !rsp_valid)
   `MPQ_ASSERT_NEXT(a_busy_answers, clock, reset, busy, rsp_valid && !busy)
   // A remove on an empty queue reports -1 and zero occupancy.
   `MPQ_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && rsp_data.status == STATUS_EMPTY,
      rsp_data.result_value == -32'sd1 && rsp_data.occupancy == '0)
   // A dropped insert is only reported when the queue is full.
   `MPQ_ASSERT_NOW(a_full_result, clock, reset, rsp_valid && rsp_data.status == STATUS_FULL,
      rsp_data.occupancy == OCCUPANCY_WIDTH'(CAPACITY) && rsp_data.result_value == '0)

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (.*);
`default_nettype wire

/* bench/tb_max_priority_queue.sv */
`default_nettype none
module tb_max_priority_queue;
   import mpq_pkg::*;

   // Run limits: the cycle ceiling is several times the slowest correct run.
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MAX_GAP        = 24;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PRINT_LIMIT    = 100;
   localparam int RANDOM_PER_RUN = 600;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   request_type  req_data;
   logic         rsp_valid;
   response_type rsp_data;

   int sender_idle_pct = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   // Shadow of the queue contents; order inside is irrelevant, only the
   // greatest value is ever observed.
   logic signed [DATA_WIDTH-1:0] held_values[$];
   // Responses predicted at each accepted transfer, oldest first.
   response_type                 pending_responses[$];

   max_priority_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("** max_priority_queue: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s expected %h got %h",
                  cycle_count, what, want, got);
   endtask

   // Update the shadow queue for one request and work out its response.
   task automatic apply_request(input request_type req, output response_type rsp);
      int best;
      rsp = '0;
      if (req.req_type == REQ_INSERT) begin
         // Drop the value when every slot is taken.
         if (held_values.size() >= CAPACITY) begin
            rsp.status = STATUS_FULL;
         end else begin
            held_values = {held_values, req.value[DATA_WIDTH-1:0]};
            rsp.status = STATUS_OK;
         end
      end else begin
         if (held_values.size() == 0) begin
            rsp.result_value = -1;
            rsp.status       = STATUS_EMPTY;
         end else begin
            best = 0;
            for (int i = 1; i < held_values.size(); i++)
               if (held_values[i] > held_values[best])
                  best = i;
            rsp.result_value = RESULT_WIDTH'(held_values[best]);
            rsp.status       = STATUS_OK;
            held_values.delete(best);
         end
      end
      rsp.occupancy = OCCUPANCY_WIDTH'(held_values.size());
   endtask

   // Send one request. Enter and leave just after a falling edge; keep start
   // high across back-to-back transfers so it is never dropped and raised
   // in the same step.
   task automatic send_request(input logic kind, input logic signed [31:0] value);
      request_type  item;
      response_type rsp;
      int           gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      item.req_type = kind;
      item.value    = value;
      start    <= 1'b1;
      req_data <= item;
      // Hold the request until an edge sees busy low.
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      apply_request(item, rsp);
      pending_responses = {pending_responses, rsp};
      @(negedge clock);
   endtask

   // Mostly full-range values, with extremes and a narrow band that forces
   // equal entries into the queue.
   function automatic logic signed [31:0] random_value();
      logic signed [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = 32'sh7fff_ffff;
               1: v = 32'sh8000_0000;
               2: v = -1;
               default: v = 0;
            endcase
         end
         1: v = $signed($urandom_range(7)) - 4;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Check every strobed response against the oldest prediction.
   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with none outstanding", 32'd0,
                            rsp_data.result_value);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", want.result_value,
                               rsp_data.result_value);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.occupancy !== want.occupancy)
               report_mismatch("occupancy", 32'(want.occupancy),
                               32'(rsp_data.occupancy));
         end
      end
   end

   // Remove from the queue straight after reset: expect -1 and the empty status.
   task automatic test_remove_empty();
      send_request(REQ_REMOVE, $urandom);
      send_request(REQ_REMOVE, 32'sh7fff_ffff);
   endtask

   // Insert the extremes, equal values and neighbors, then drain past empty.
   task automatic test_extremes();
      send_request(REQ_INSERT, 32'sh8000_0000);
      send_request(REQ_INSERT, 32'sh7fff_ffff);
      send_request(REQ_INSERT, 0);
      send_request(REQ_INSERT, -1);
      send_request(REQ_INSERT, 1);
      send_request(REQ_INSERT, 32'sh7fff_fffe);
      send_request(REQ_INSERT, 32'sh8000_0001);
      send_request(REQ_INSERT, 5);
      send_request(REQ_INSERT, 5);
      send_request(REQ_INSERT, 32'sh5555_aaaa);
      repeat (11) send_request(REQ_REMOVE, $urandom);
      // Removing the most negative value alone checks the sign handling.
      send_request(REQ_INSERT, 32'sh8000_0000);
      send_request(REQ_REMOVE, 0);
   endtask

   // Fill to capacity, push inserts that must be dropped, then drain fully.
   task automatic test_full_queue();
      repeat (CAPACITY) send_request(REQ_INSERT, random_value());
      repeat (3) send_request(REQ_INSERT, random_value());
      send_request(REQ_REMOVE, $urandom);
      send_request(REQ_INSERT, 32'sh7fff_ffff);
      send_request(REQ_INSERT, 32'sh7fff_ffff);
      repeat (CAPACITY + 1) send_request(REQ_REMOVE, $urandom);
   endtask

   // Random traffic in segments that lean toward inserts or removes, so the
   // queue swings between empty and full many times.
   task automatic test_random_traffic(input int idle_pct, input int count);
      int sent;
      int seg_left;
      int insert_pct;
      sender_idle_pct = idle_pct;
      sent     = 0;
      seg_left = 0;
      insert_pct = 50;
      while (sent < count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(80, 10);
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         if ($urandom_range(99) < insert_pct)
            send_request(REQ_INSERT, random_value());
         else
            send_request(REQ_REMOVE, $urandom);
         seg_left--;
         sent++;
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 11;
      test_remove_empty();
      test_extremes();
      test_full_queue();

      test_random_traffic(11, RANDOM_PER_RUN);
      test_random_traffic(52, RANDOM_PER_RUN);
      test_random_traffic(0, RANDOM_PER_RUN);

      // Release the request line and wait out the outstanding responses.
      start <= 1'b0;
      while (pending_responses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("** max_priority_queue: PASSED **");
      else
         $display("** max_priority_queue: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
